>>> rtl/ufp_pkg.sv
// Package for the UART frame parser with CRC-16/MAXIM check.
// Holds frame constants, phase and result-kind types, the result struct
// and the byte-wide CRC update. No dependencies.
`timescale 1ns / 1ps

package ufp_pkg;

  localparam logic [7:0]  HDR_BYTE    = 8'hE6;
  localparam logic [7:0]  TAIL_BYTE   = 8'h6E;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'h0000;
  localparam int          MAX_PAYLOAD = 1024;
  localparam int          CNT_W       = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [3:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_SEQ_H,
    PH_SEQ_L,
    PH_CMD,
    PH_LEN_H,
    PH_LEN_L,
    PH_DATA,
    PH_CRC_H,
    PH_CRC_L,
    PH_TAIL1,
    PH_TAIL2_OK,
    PH_TAIL2_BAD
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA    = 3'd0,
    K_GOOD    = 3'd1,
    K_CRCERR  = 3'd2,
    K_TAILERR = 3'd3,
    K_LENERR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] seq_id;
    logic [7:0]  command;
    logic [15:0] payload_len;
    logic        frame_end;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/ufp_if.sv
// Valid/ready channel interfaces for the UART frame parser.
// Depends on ufp_pkg for the result kind type.
`timescale 1ns / 1ps

interface ufp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufp_out_if
  import ufp_pkg::*;
;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  data_byte;
  logic [15:0] seq_id;
  logic [7:0]  command;
  logic [15:0] payload_len;
  logic        frame_end;

  modport source (output valid, output kind, output data_byte, output seq_id,
                  output command, output payload_len, output frame_end,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input seq_id,
                  input command, input payload_len, input frame_end,
                  output ready);
endinterface

>>> rtl/ufp_deframer.sv
// Frame phase tracker: header hunt, field capture, CRC accumulation and
// end-of-frame status. Depends on ufp_pkg.
`timescale 1ns / 1ps

module ufp_deframer
  import ufp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  phase_t             phase_r, phase_nxt;
  logic [15:0]        seq_r, seq_nxt;
  logic [7:0]         cmd_r, cmd_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic [15:0]        chk_r, chk_nxt;
  logic [15:0]        crc_upd;
  logic [CNT_W-1:0]   cnt_inc;

  assign crc_upd = crc16_byte(crc_r, rx_byte);
  assign cnt_inc = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      seq_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= CRC_INIT;
      chk_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    chk_nxt   = chk_r;
    res_valid = 1'b0;
    res.kind      = K_DATA;
    res.data_byte = '0;
    res.frame_end = 1'b0;

    unique case (phase_r)
      PH_HUNT1: begin
        if (rx_byte == HDR_BYTE) phase_nxt = PH_HUNT2;
      end
      PH_HUNT2: begin
        phase_nxt = (rx_byte == HDR_BYTE) ? PH_SEQ_H : PH_HUNT1;
        crc_nxt   = CRC_INIT;
      end
      PH_SEQ_H: begin
        seq_nxt   = {rx_byte, 8'h00};
        crc_nxt   = crc_upd;
        phase_nxt = PH_SEQ_L;
      end
      PH_SEQ_L: begin
        seq_nxt   = {seq_r[15:8], rx_byte};
        crc_nxt   = crc_upd;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN_H;
      end
      PH_LEN_H: begin
        len_nxt   = {rx_byte, 8'h00};
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN_L;
      end
      PH_LEN_L: begin
        len_nxt = {len_r[15:8], rx_byte};
        crc_nxt = crc_upd;
        cnt_nxt = '0;
        if (len_nxt > 16'(MAX_PAYLOAD)) begin
          phase_nxt     = PH_HUNT1;
          res_valid     = 1'b1;
          res.kind      = K_LENERR;
          res.frame_end = 1'b1;
        end else begin
          phase_nxt = (len_nxt == 16'h0000) ? PH_CRC_H : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if (16'(cnt_inc) >= len_r) phase_nxt = PH_CRC_H;
        res_valid     = 1'b1;
        res.kind      = K_DATA;
        res.data_byte = rx_byte;
      end
      PH_CRC_H: begin
        chk_nxt   = {rx_byte, 8'h00};
        phase_nxt = PH_CRC_L;
      end
      PH_CRC_L: begin
        chk_nxt   = {chk_r[15:8], rx_byte};
        phase_nxt = PH_TAIL1;
      end
      PH_TAIL1: begin
        phase_nxt = (rx_byte == TAIL_BYTE) ? PH_TAIL2_OK : PH_TAIL2_BAD;
      end
      PH_TAIL2_OK, PH_TAIL2_BAD: begin
        if (phase_r == PH_TAIL2_BAD || rx_byte != TAIL_BYTE) begin
          res.kind = K_TAILERR;
        end else if (~crc_r != chk_r) begin
          res.kind = K_CRCERR;
        end else begin
          res.kind = K_GOOD;
        end
        phase_nxt     = PH_HUNT1;
        res_valid     = 1'b1;
        res.frame_end = 1'b1;
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase

    res.seq_id      = seq_nxt;
    res.command     = cmd_nxt;
    res.payload_len = len_nxt;
  end

endmodule

>>> rtl/uart_frame_parser_crc16_core.sv
// Top level of the UART frame parser with CRC-16/MAXIM check.
// Depends on ufp_pkg, ufp_in_if, ufp_out_if and ufp_deframer.
//
// Usage:
//   in_ch carries received bytes (rx_byte), one per transfer. out_ch carries
//   results: payload bytes (kind 0) as they arrive, and one status per frame
//   (good, crc mismatch, tail error, length error) with frame_end set.
//   seq_id, command and payload_len report the fields of the current frame.
//   A byte is taken in every cycle while the output register is empty or
//   being drained; throughput is one byte per cycle.
//   A result is on out_ch in the cycle after its byte's transfer. Header,
//   field, check and first tail bytes produce no result but a length error.
//   When the receiver stalls, the result holds in the output register and
//   in_ch.ready drops until it is taken; no result is lost.
//   Synchronous reset (rst_n low) returns the parser to hunting for the
//   first header byte, clears the captured fields and empties the output.
//   A declared length above 1024 ends the frame with a length error and
//   hunting resumes with the next byte.
`timescale 1ns / 1ps

module uart_frame_parser_crc16_core
  import ufp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ufp_in_if.sink    in_ch,
  ufp_out_if.source out_ch
);

  logic out_valid_r;
  res_t out_res_r;
  logic take;
  logic res_valid;
  res_t res;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  ufp_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_ch.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.data_byte   = out_res_r.data_byte;
  assign out_ch.seq_id      = out_res_r.seq_id;
  assign out_ch.command     = out_res_r.command;
  assign out_ch.payload_len = out_res_r.payload_len;
  assign out_ch.frame_end   = out_res_r.frame_end;

endmodule

>>> tb/ufp_deframe_checker.sv
// Checker for the UART frame parser: watches the byte and result channels,
// predicts every result from the accepted bytes and compares it field by field.
// Depends on ufp_pkg and the ufp_in_if / ufp_out_if interfaces.
`timescale 1ns / 1ps

module ufp_deframe_checker
  import ufp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ufp_in_if    in_mon,
  ufp_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);

  phase_t           pstate    = PH_HUNT1;
  logic [15:0]      cur_seq   = '0;
  logic [7:0]       cur_cmd   = '0;
  logic [15:0]      cur_len   = '0;
  logic [CNT_W-1:0] pay_cnt   = '0;
  logic [15:0]      crc_run   = '0;
  logic [15:0]      got_check = '0;
  res_t             expected_results[$];
  int               errors    = 0;

  function automatic logic [15:0] crc_maxim(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("kind=%0d data=%02h seq=%04h cmd=%02h len=%0d end=%0b",
                     r.kind, r.data_byte, r.seq_id, r.command, r.payload_len, r.frame_end);
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    res_t  r;
    kind_t k;
    logic  produces;
    k = K_DATA;
    produces = 1'b0;
    case (pstate)
      PH_HUNT1: begin
        if (b == HDR_BYTE) begin
          pstate = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        pstate = (b == HDR_BYTE) ? PH_SEQ_H : PH_HUNT1;
        crc_run = CRC_INIT;
      end
      PH_SEQ_H: begin
        cur_seq = {b, 8'h00};
        crc_run = crc_maxim(crc_run, b);
        pstate = PH_SEQ_L;
      end
      PH_SEQ_L: begin
        cur_seq[7:0] = b;
        crc_run = crc_maxim(crc_run, b);
        pstate = PH_CMD;
      end
      PH_CMD: begin
        cur_cmd = b;
        crc_run = crc_maxim(crc_run, b);
        pstate = PH_LEN_H;
      end
      PH_LEN_H: begin
        cur_len = {b, 8'h00};
        crc_run = crc_maxim(crc_run, b);
        pstate = PH_LEN_L;
      end
      PH_LEN_L: begin
        cur_len[7:0] = b;
        crc_run = crc_maxim(crc_run, b);
        pay_cnt = '0;
        if (cur_len > 16'(MAX_PAYLOAD)) begin
          pstate = PH_HUNT1;
          k = K_LENERR;
          produces = 1'b1;
        end else begin
          pstate = (cur_len == 16'd0) ? PH_CRC_H : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_run = crc_maxim(crc_run, b);
        pay_cnt = pay_cnt + 1'b1;
        if (16'(pay_cnt) >= cur_len) begin
          pstate = PH_CRC_H;
        end
        k = K_DATA;
        produces = 1'b1;
      end
      PH_CRC_H: begin
        got_check = {b, 8'h00};
        pstate = PH_CRC_L;
      end
      PH_CRC_L: begin
        got_check[7:0] = b;
        pstate = PH_TAIL1;
      end
      PH_TAIL1: begin
        pstate = (b == TAIL_BYTE) ? PH_TAIL2_OK : PH_TAIL2_BAD;
      end
      PH_TAIL2_OK, PH_TAIL2_BAD: begin
        if (pstate == PH_TAIL2_BAD || b != TAIL_BYTE) begin
          k = K_TAILERR;
        end else if (~crc_run != got_check) begin
          k = K_CRCERR;
        end else begin
          k = K_GOOD;
        end
        pstate = PH_HUNT1;
        produces = 1'b1;
      end
      default: begin
        pstate = PH_HUNT1;
      end
    endcase
    if (produces) begin
      r.kind        = k;
      r.data_byte   = (k == K_DATA) ? b : 8'h00;
      r.seq_id      = cur_seq;
      r.command     = cur_cmd;
      r.payload_len = cur_len;
      r.frame_end   = (k != K_DATA);
      expected_results.push_back(r);
    end
  endtask

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t ERROR %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        parse_byte(in_mon.rx_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.kind        = out_mon.kind;
        got.data_byte   = out_mon.data_byte;
        got.seq_id      = out_mon.seq_id;
        got.command     = out_mon.command;
        got.payload_len = out_mon.payload_len;
        got.frame_end   = out_mon.frame_end;
        if (expected_results.size() == 0) begin
          note_failure({"result with nothing pending: ", show(got)});
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.seq_id !== want.seq_id || got.command !== want.command ||
              got.payload_len !== want.payload_len || got.frame_end !== want.frame_end) begin
            note_failure({"expected ", show(want), " got ", show(got)});
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= expected_results.size();
  end

endmodule

>>> tb/uart_frame_parser_crc16_core_test.sv
// Top of the UART frame parser test: clock, reset, framed byte stimulus with
// random idling and a long receiver hold-off, watchdog and final verdict.
// Depends on ufp_pkg, the channel interfaces, the core and ufp_deframe_checker.
`timescale 1ns / 1ps

module uart_frame_parser_crc16_core_test;
  import ufp_pkg::*;

  localparam int         ITEMS        = 1250;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         STALL_LIMIT  = 5000;
  localparam int         DRAIN_CYCLES = 16;
  localparam logic [3:0] FLT_CRC      = 4'b0001;
  localparam logic [3:0] FLT_TAIL1    = 4'b0010;
  localparam logic [3:0] FLT_TAIL2    = 4'b0100;
  localparam logic [3:0] FLT_TRUNC    = 4'b1000;

  logic       clk = 1'b0;
  logic       rst_n;
  int         fail_count;
  int         outstanding;
  int         send_idle = 0;
  int         stall_pct = 0;
  int         items     = 0;
  int         goal;
  logic       hold_tgl  = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  int         idle_run  = 0;
  logic [7:0] frame_bytes[$];

  ufp_in_if  in_ch ();
  ufp_out_if out_ch ();

  uart_frame_parser_crc16_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ufp_deframe_checker frame_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] frame_crc(input logic [15:0] c, input logic [7:0] b);
    c = c ^ {8'h00, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(7))
      0: return HDR_BYTE;
      1: return TAIL_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom); while (b == avoid);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items++;
  endtask

  task automatic send_frame(input logic [15:0] seq, input logic [7:0] cmd,
                            input logic [15:0] len, input logic [3:0] faults);
    logic [7:0]  fields[5];
    logic [7:0]  b;
    logic [15:0] crc;
    logic [15:0] check;
    fields = '{seq[15:8], seq[7:0], cmd, len[15:8], len[7:0]};
    frame_bytes = {HDR_BYTE, HDR_BYTE};
    crc = CRC_INIT;
    foreach (fields[i]) begin
      frame_bytes.push_back(fields[i]);
      crc = frame_crc(crc, fields[i]);
    end
    if (len <= 16'(MAX_PAYLOAD)) begin
      repeat (len) begin
        b = payload_byte();
        frame_bytes.push_back(b);
        crc = frame_crc(crc, b);
      end
      check = ~crc;
      if ((faults & FLT_CRC) != 0) begin
        check = check ^ (16'd1 << $urandom_range(15));
      end
      frame_bytes.push_back(check[15:8]);
      frame_bytes.push_back(check[7:0]);
      frame_bytes.push_back(((faults & FLT_TAIL1) != 0) ? other_than(TAIL_BYTE) : TAIL_BYTE);
      frame_bytes.push_back(((faults & FLT_TAIL2) != 0) ? other_than(TAIL_BYTE) : TAIL_BYTE);
      if ((faults & FLT_TRUNC) != 0) begin
        repeat ($urandom_range(4, 1)) void'(frame_bytes.pop_back());
      end
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  task automatic random_frame();
    int          pick;
    logic [15:0] seq;
    logic [15:0] len;
    logic [7:0]  cmd;
    logic [3:0]  faults;
    pick = $urandom_range(99);
    seq  = 16'($urandom);
    cmd  = 8'($urandom);
    len  = 16'($urandom_range(12));
    if (pick < 55) begin
      send_frame(seq, cmd, len, '0);
    end else if (pick < 63) begin
      send_frame(seq, cmd, len, FLT_CRC);
    end else if (pick < 71) begin
      case ($urandom_range(2))
        0: faults = FLT_TAIL1;
        1: faults = FLT_TAIL2;
        default: faults = FLT_TAIL1 | FLT_TAIL2;
      endcase
      if ($urandom_range(1) == 1) begin
        faults = faults | FLT_CRC;
      end
      send_frame(seq, cmd, len, faults);
    end else if (pick < 77) begin
      case ($urandom_range(2))
        0: len = 16'(MAX_PAYLOAD + 1);
        1: len = 16'hFFFF;
        default: len = 16'($urandom_range(65535, MAX_PAYLOAD + 1));
      endcase
      send_frame(seq, cmd, len, '0);
    end else if (pick < 82) begin
      send_byte(HDR_BYTE);
      send_byte(other_than(HDR_BYTE));
    end else if (pick < 88) begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
    end else if (pick < 93) begin
      send_frame(seq, cmd, len, FLT_TRUNC);
    end else begin
      send_frame(seq, cmd, 16'($urandom_range(64, 13)), '0);
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("uart_frame_parser_crc16_core: mismatch");
      $finish;
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    rst_n         <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(HDR_BYTE);
    send_byte(8'h41);
    send_frame(16'h0000, 8'h00, 16'd0, '0);
    send_frame(16'hFFFF, 8'hFF, 16'hFFFF, '0);
    send_frame(16'hFFFF, 8'hFF, 16'd1, FLT_CRC);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle = 80;
          stall_pct <= 0;
        end
        2: begin
          send_idle = 0;
          stall_pct <= 80;
        end
        default: begin
          send_idle = 32;
          stall_pct <= 32;
        end
      endcase
      if (p == 0) begin
        hold_tgl <= ~hold_tgl;
        send_frame(16'($urandom), 8'($urandom), 16'd40, '0);
      end
      goal = items + ITEMS / 4;
      while (items < goal) begin
        random_frame();
      end
    end

    in_ch.valid <= 1'b0;
    stall_pct   <= 0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("uart_frame_parser_crc16_core: match");
    end else begin
      $display("uart_frame_parser_crc16_core: mismatch");
    end
    $finish;
  end

endmodule
